// File: rtl/dado_pkg.sv
// ----------------------------------------------------------------------------
// dado_pkg
// shared types, constants and the cordic arctangent table for the odometry
// ----------------------------------------------------------------------------
`default_nettype none

package dado_pkg;

    localparam int MAG_W  = 34;             // multiplier operand magnitude
    localparam int HALF_W = MAG_W / 2;      // multiplier partial width
    localparam int PROD_W = 2 * MAG_W;      // product magnitude
    localparam int DIV_W  = 64;             // quotient width
    localparam int DEN_W  = 63;             // numerator and divisor magnitude
    localparam int TRIG_W = 34;             // cordic x, y, z width
    localparam int IN_W   = 48;             // slave tdata width
    localparam int OUT_W  = 96;             // master tdata width

    localparam logic [31:0]              QUARTER_TURN = 32'h4000_0000;
    localparam logic [MAG_W-1:0]         RAD_TO_BAM   = 34'd683565276;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [MAG_W-1:0]  ONE_Q30      = 34'sd1073741824;
    localparam logic [DEN_W-1:0]         SMALL_H      = 63'd67108864;
    localparam logic [31:0]              DPC_RST      = 32'd125829;
    localparam logic [23:0]              WB_RST       = 24'd1245184;
    localparam logic [4:0]               CORDIC_LAST  = 5'd30;

    typedef enum logic {
        CFG_DPC = 1'b0,
        CFG_WB  = 1'b1
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE, S_D1, S_D1W, S_D2, S_D2W, S_CHK,
        S_TH, S_THW, S_THD, S_THDW, S_HQ, S_HQW,
        S_SQ1, S_SQ1W, S_SQ2, S_SQ2W, S_DV6, S_DV6W, S_DV120, S_DV120W,
        S_CH, S_CHW, S_SD, S_SDW, S_LEN, S_LENW,
        S_CD, S_CDW, S_MX, S_MXW, S_MY, S_MYW, S_UPD
    } t_state;

    typedef struct packed {
        logic              go;
        logic              neg;
        logic [MAG_W-1:0]  a;
        logic [MAG_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [PROD_W-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic             go;
        logic             neg;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] q;
    } t_div_rsp;

    typedef struct packed {
        logic        go;
        logic [31:0] ang;
    } t_cor_req;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_cor_rsp;

    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/differential_drive_arc_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_arc_odometry
// two-wheel arc odometry: keeps x, y and heading and reports the new pose
// ----------------------------------------------------------------------------
// One word in gives one pose word out. s_axis_tready is high only in the idle
// state, so a word holds the block for its whole computation. The path taken
// depends on the move: a straight move (zero elapsed time or equal wheel
// distances), a gentle arc (half turn angle below 1/16 rad) or a sharper arc.
// The computation time is set by the shared 64-step restoring divider (two divisions on
// a gentle arc, three on a sharper one), then by the 31-step cordic (one or
// two passes) and the multiplier, which also handles the sinc series
// constants through reciprocals. A finished pose sits in the output register
// while the next word is already being worked on; that word then waits in its
// last state for as long as the output register is still full. Configuration
// writes are taken at any time and must only be issued while idle.
`default_nettype none

module differential_drive_arc_odometry (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_wheel_counts, second_wheel_counts, elapsed_ms
    input  wire logic [dado_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // pos_x, pos_y, heading
    output logic [dado_pkg::OUT_W-1:0]      m_axis_tdata,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [31:0]                i_cfg_data
);
    import dado_pkg::*;

    // round(n / 6) and round(n / 120) as (n + d/2) * ceil(2^32 / d) >> 32
    localparam logic [MAG_W-1:0] RECIP_SIX    = 34'd715827883;
    localparam logic [MAG_W-1:0] RND_SIX      = 34'd3;
    localparam logic [MAG_W-1:0] RECIP_120    = 34'd35791395;
    localparam logic [MAG_W-1:0] RND_120      = 34'd60;
    localparam logic signed [36:0] POS_MAX    = 37'sd2147483647;
    localparam logic signed [36:0] POS_MIN    = -37'sd2147483648;

    t_state                   r_state, n_state;
    logic                     r_oval;
    logic [31:0]              r_dpc;
    logic [23:0]              r_wb;
    logic signed [31:0]       r_x;
    logic signed [31:0]       r_y;
    logic [31:0]              r_hd;
    logic [15:0]              r_c1;
    logic [15:0]              r_c2;
    logic                     r_el_zero;
    logic signed [31:0]       r_d1;
    logic signed [31:0]       r_d2;
    logic signed [MAG_W-1:0]  r_diff;
    logic signed [MAG_W-1:0]  r_s;
    logic [32:0]              r_dth;
    logic [DEN_W-1:0]         r_mag;
    logic [MAG_W-1:0]         r_h2;
    logic [MAG_W-1:0]         r_h4;
    logic signed [MAG_W-1:0]  r_sinc;
    logic signed [MAG_W-1:0]  r_len;
    logic signed [35:0]       r_dx;
    logic signed [35:0]       r_dy;

    t_mul_req                 mul_req;
    t_mul_rsp                 mul_rsp;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    t_cor_req                 cor_req;
    t_cor_rsp                 cor_rsp;

    logic [DEN_W-1:0]         w_base;
    logic [DIV_W-1:0]         w_qabs;
    logic [MAG_W-1:0]         w_sh_abs;
    logic signed [32:0]       w_sum;
    logic [32:0]              w_sum_abs;
    logic [32:0]              w_half;
    logic signed [36:0]       w_nx;
    logic signed [36:0]       w_ny;
    logic [MAG_W-1:0]         w_recip_q;

    function automatic logic [MAG_W-1:0] f_abs(input logic signed [MAG_W-1:0] v);
        return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // product magnitude to signed, divided by 2^30 with rounding
    function automatic logic signed [35:0] f_rnd30(input logic [PROD_W-1:0] m,
                                                   input logic neg);
        logic [PROD_W-1:0] t;
        logic [35:0]       u;
        t = (m + (PROD_W'(1) << 29)) >> 30;
        u = {1'b0, t[34:0]};
        return neg ? -$signed(u) : $signed(u);
    endfunction

    // counts times scale, q8.24 to q16.16 with rounding, saturated
    function automatic logic signed [31:0] f_wdist(input logic [PROD_W-1:0] m,
                                                   input logic neg);
        logic [PROD_W-1:0] t;
        logic [31:0]       r;
        t = (m + PROD_W'(128)) >> 8;
        if (!neg) begin
            r = (t > PROD_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : t[31:0];
        end else begin
            r = (t > PROD_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-t[31:0]);
        end
        return $signed(r);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > POS_MAX) begin
            r = 32'sh7fff_ffff;
        end else if (v < POS_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    dado_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    dado_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dado_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    assign w_base    = (r_wb == 24'd0) ? DEN_W'(1) : {39'd0, r_wb};
    assign w_qabs    = div_rsp.q[DIV_W-1] ? DIV_W'(-div_rsp.q) : DIV_W'(div_rsp.q);
    assign w_sh_abs  = f_abs(cor_rsp.s);
    assign w_sum     = {r_d1[31], r_d1} + {r_d2[31], r_d2};
    assign w_sum_abs = w_sum[32] ? 33'(-w_sum) : 33'(w_sum);
    assign w_half    = (w_sum_abs + 33'd1) >> 1;
    assign w_nx      = {{5{r_x[31]}}, r_x} + {r_dx[35], r_dx};
    assign w_ny      = {{5{r_y[31]}}, r_y} + {r_dy[35], r_dy};
    assign w_recip_q = mul_rsp.p[MAG_W+31:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {r_hd, r_y, r_x};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_axis_tvalid) n_state = S_D1;
            S_D1:     n_state = S_D1W;
            S_D1W:    if (mul_rsp.done) n_state = S_D2;
            S_D2:     n_state = S_D2W;
            S_D2W:    if (mul_rsp.done) n_state = S_CHK;
            S_CHK:    n_state = (r_el_zero || r_d1 == r_d2) ? S_CD : S_TH;
            S_TH:     n_state = S_THW;
            S_THW:    if (mul_rsp.done) n_state = S_THD;
            S_THD:    n_state = S_THDW;
            S_THDW:   if (div_rsp.done) n_state = S_HQ;
            S_HQ:     n_state = S_HQW;
            S_HQW: begin
                if (div_rsp.done) begin
                    n_state = (w_qabs[DEN_W-1:0] < SMALL_H) ? S_SQ1 : S_CH;
                end
            end
            S_SQ1:    n_state = S_SQ1W;
            S_SQ1W:   if (mul_rsp.done) n_state = S_SQ2;
            S_SQ2:    n_state = S_SQ2W;
            S_SQ2W:   if (mul_rsp.done) n_state = S_DV6;
            S_DV6:    n_state = S_DV6W;
            S_DV6W:   if (mul_rsp.done) n_state = S_DV120;
            S_DV120:  n_state = S_DV120W;
            S_DV120W: if (mul_rsp.done) n_state = S_LEN;
            S_CH:     n_state = S_CHW;
            S_CHW:    if (cor_rsp.done) n_state = S_SD;
            S_SD:     n_state = S_SDW;
            S_SDW:    if (div_rsp.done) n_state = S_LEN;
            S_LEN:    n_state = S_LENW;
            S_LENW:   if (mul_rsp.done) n_state = S_CD;
            S_CD:     n_state = S_CDW;
            S_CDW:    if (cor_rsp.done) n_state = S_MX;
            S_MX:     n_state = S_MXW;
            S_MXW:    if (mul_rsp.done) n_state = S_MY;
            S_MY:     n_state = S_MYW;
            S_MYW:    if (mul_rsp.done) n_state = S_UPD;
            S_UPD:    if (!r_oval || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // unit requests
    always_comb begin
        mul_req = '0;
        div_req = '0;
        cor_req = '0;
        unique case (r_state)
            S_D1: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs({{18{r_c1[15]}}, r_c1});
                mul_req.b   = {2'b00, r_dpc};
                mul_req.neg = r_c1[15];
            end
            S_D2: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs({{18{r_c2[15]}}, r_c2});
                mul_req.b   = {2'b00, r_dpc};
                mul_req.neg = r_c2[15];
            end
            S_TH: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs(r_diff);
                mul_req.b   = RAD_TO_BAM;
                mul_req.neg = r_diff[MAG_W-1];
            end
            S_THD: begin
                div_req.go  = 1'b1;
                div_req.num = mul_rsp.p[DEN_W-1:0];
                div_req.den = w_base;
                div_req.neg = mul_rsp.neg;
            end
            S_HQ: begin
                div_req.go  = 1'b1;
                div_req.num = {f_abs(r_diff), 29'd0};
                div_req.den = w_base;
                div_req.neg = r_diff[MAG_W-1];
            end
            S_SQ1: begin
                mul_req.go = 1'b1;
                mul_req.a  = r_mag[MAG_W-1:0];
                mul_req.b  = r_mag[MAG_W-1:0];
            end
            S_SQ2: begin
                mul_req.go = 1'b1;
                mul_req.a  = r_h2;
                mul_req.b  = r_h2;
            end
            S_DV6: begin
                mul_req.go = 1'b1;
                mul_req.a  = r_h2 + RND_SIX;
                mul_req.b  = RECIP_SIX;
            end
            S_DV120: begin
                mul_req.go = 1'b1;
                mul_req.a  = r_h4 + RND_120;
                mul_req.b  = RECIP_120;
            end
            S_CH: begin
                cor_req.go  = 1'b1;
                cor_req.ang = r_dth[32:1];
            end
            S_SD: begin
                div_req.go  = 1'b1;
                div_req.num = {w_sh_abs[32:0], 30'd0};
                div_req.den = r_mag;
                div_req.neg = cor_rsp.s[TRIG_W-1] ^ r_diff[MAG_W-1];
            end
            S_LEN: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs(r_s);
                mul_req.b   = f_abs(r_sinc);
                mul_req.neg = r_s[MAG_W-1] ^ r_sinc[MAG_W-1];
            end
            S_CD: begin
                cor_req.go  = 1'b1;
                cor_req.ang = r_hd - r_dth[32:1] + QUARTER_TURN;
            end
            S_MX: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs(r_len);
                mul_req.b   = f_abs(cor_rsp.c);
                mul_req.neg = r_len[MAG_W-1] ^ cor_rsp.c[TRIG_W-1];
            end
            S_MY: begin
                mul_req.go  = 1'b1;
                mul_req.a   = f_abs(r_len);
                mul_req.b   = f_abs(cor_rsp.s);
                mul_req.neg = r_len[MAG_W-1] ^ cor_rsp.s[TRIG_W-1];
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // control, pose and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_hd    <= '0;
            r_dpc   <= DPC_RST;
            r_wb    <= WB_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_DPC: r_dpc <= i_cfg_data;
                    CFG_WB:  r_wb  <= i_cfg_data[23:0];
                endcase
            end
            if (r_state == S_UPD && (!r_oval || m_axis_tready)) begin
                r_oval <= 1'b1;
                r_x    <= f_sat(w_nx);
                r_y    <= f_sat(w_ny);
                r_hd   <= r_hd - r_dth[31:0];
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    r_c1      <= s_axis_tdata[15:0];
                    r_c2      <= s_axis_tdata[31:16];
                    r_el_zero <= (s_axis_tdata[47:32] == 16'd0);
                end
            end
            S_D1W: if (mul_rsp.done) r_d1 <= f_wdist(mul_rsp.p, mul_rsp.neg);
            S_D2W: if (mul_rsp.done) r_d2 <= f_wdist(mul_rsp.p, mul_rsp.neg);
            S_CHK: begin
                // straight moves use zero turn, so the arc path below is shared
                r_len  <= {{2{r_d1[31]}}, r_d1};
                r_dth  <= '0;
                r_diff <= {{2{r_d1[31]}}, r_d1} - {{2{r_d2[31]}}, r_d2};
                r_s    <= w_sum[32] ? -$signed({1'b0, w_half}) : $signed({1'b0, w_half});
            end
            S_THDW: if (div_rsp.done) r_dth <= div_rsp.q[32:0];
            S_HQW:  if (div_rsp.done) r_mag <= w_qabs[DEN_W-1:0];
            S_SQ1W: if (mul_rsp.done) r_h2 <= MAG_W'(f_rnd30(mul_rsp.p, 1'b0));
            S_SQ2W: if (mul_rsp.done) r_h4 <= MAG_W'(f_rnd30(mul_rsp.p, 1'b0));
            S_DV6W: if (mul_rsp.done) r_h2 <= w_recip_q;
            S_DV120W: begin
                if (mul_rsp.done) begin
                    r_sinc <= ONE_Q30 - $signed(r_h2) + $signed(w_recip_q);
                end
            end
            S_SDW:  if (div_rsp.done) r_sinc <= div_rsp.q[MAG_W-1:0];
            S_LENW: if (mul_rsp.done) r_len <= MAG_W'(f_rnd30(mul_rsp.p, mul_rsp.neg));
            S_MXW:  if (mul_rsp.done) r_dx <= f_rnd30(mul_rsp.p, mul_rsp.neg);
            S_MYW:  if (mul_rsp.done) r_dy <= f_rnd30(mul_rsp.p, mul_rsp.neg);
            default: begin
                r_c1 <= r_c1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dado_mul.sv
// ----------------------------------------------------------------------------
// dado_mul
// unsigned magnitude multiplier, one 34x17 partial product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dado_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  dado_pkg::t_mul_req     i_req,
    output dado_pkg::t_mul_rsp     o_rsp
);
    import dado_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic                     r_ph;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_a;
    logic [MAG_W-1:0]         r_b;
    logic [PROD_W-1:0]        r_p;
    logic [HALF_W-1:0]        w_bsel;
    logic [MAG_W+HALF_W-1:0]  w_part;
    logic [PROD_W-1:0]        w_shift;

    assign w_bsel  = r_ph ? r_b[MAG_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign w_part  = r_a * w_bsel;
    assign w_shift = r_ph ? {w_part, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, w_part};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
            end else if (r_busy) begin
                r_ph <= 1'b1;
                if (r_ph) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_neg <= i_req.neg;
            r_p   <= '0;
        end else if (r_busy) begin
            r_p <= r_p + w_shift;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.p    = r_p;

endmodule

`default_nettype wire

// File: rtl/dado_div.sv
// ----------------------------------------------------------------------------
// dado_div
// restoring divider, one quotient bit per cycle, rounds half away from zero
// ----------------------------------------------------------------------------
`default_nettype none

module dado_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  dado_pkg::t_div_req     i_req,
    output dado_pkg::t_div_rsp     o_rsp
);
    import dado_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic [DIV_W-1:0]  r_nq;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DIV_W-1:0]  w_trial;
    logic [DIV_W-1:0]  w_sub;
    logic              w_ge;

    assign w_trial = {r_rem, r_nq[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator is pre-biased by half the divisor for rounding
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_nq  <= {1'b0, i_req.num} + {2'b0, i_req.den[DEN_W-1:1]};
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_nq  <= {r_nq[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_neg ? -$signed(r_nq) : $signed(r_nq);

endmodule

`default_nettype wire

// File: rtl/dado_cordic.sv
// ----------------------------------------------------------------------------
// dado_cordic
// rotation cordic, 31 iterations, cosine and sine in q4.30
// ----------------------------------------------------------------------------
`default_nettype none

module dado_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  dado_pkg::t_cor_req     i_req,
    output dado_pkg::t_cor_rsp     o_rsp
);
    import dado_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    logic [4:0]               r_i;
    logic [1:0]               r_q;
    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [TRIG_W-1:0] r_z;
    logic [31:0]              w_sum;
    logic [1:0]               w_q;
    logic [31:0]              w_rem;
    logic signed [TRIG_W-1:0] w_dx;
    logic signed [TRIG_W-1:0] w_dy;
    logic signed [TRIG_W-1:0] w_at;

    // fold the angle into the quadrant around zero
    assign w_sum = i_req.ang + 32'h2000_0000;
    assign w_q   = w_sum[31:30];
    assign w_rem = i_req.ang - {w_q, 30'd0};
    assign w_dx  = r_x >>> r_i;
    assign w_dy  = r_y >>> r_i;
    assign w_at  = $signed({2'b00, f_atan(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == CORDIC_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_q <= w_q;
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= $signed({{2{w_rem[31]}}, w_rem});
        end else if (r_busy) begin
            if (!r_z[TRIG_W-1]) begin
                r_x <= r_x - w_dy;
                r_y <= r_y + w_dx;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dy;
                r_y <= r_y - w_dx;
                r_z <= r_z + w_at;
            end
        end
    end

    always_comb begin
        unique case (r_q)
            2'd0: begin o_rsp.c = r_x;  o_rsp.s = r_y;  end
            2'd1: begin o_rsp.c = -r_y; o_rsp.s = r_x;  end
            2'd2: begin o_rsp.c = -r_x; o_rsp.s = -r_y; end
            default: begin o_rsp.c = r_y; o_rsp.s = -r_x; end
        endcase
        o_rsp.done = r_done;
    end

endmodule

`default_nettype wire

// File: rtl/dado_chk.sv
// ----------------------------------------------------------------------------
// dado_chk
// port-level checks for the odometry block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dado_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [dado_pkg::OUT_W-1:0] m_axis_tdata
);

    // a word in occupies the block, it is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an accepted word");

    // no result can appear in the cycle right after a word is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind differential_drive_arc_odometry dado_chk u_dado_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the arc odometry: a queued stream driver, a
// randomly stalling monitor and a fixed-point pose predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import dado_pkg::*;

    typedef struct {
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic [15:0]        ms;
    } t_move;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        hd;
    } t_pose;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    differential_drive_arc_odometry dut (.*);

    always #6 i_clk = ~i_clk;

    t_move pending_moves[$];
    t_pose expected_poses[$];
    t_move cur_move;
    int    n_fail = 0;
    int    tx_gap = 0;
    int    rx_wait = 0;
    int    hold_cycles = 0;
    int    poses_seen = 0;
    bit    hold_done = 0;

    // predictor copy of configuration and pose
    logic [31:0]        dist_per_count;
    logic [23:0]        base_len;
    logic signed [31:0] px, py;
    logic [31:0]        phd;

    localparam longint RAD_BAM = 683565276;
    localparam longint GAIN    = 652032874;
    localparam longint ONE     = 64'sd1 << 30;

    const longint atan_tab[31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1};

    function automatic longint round_div(longint n, longint d);
        logic neg;
        longint unsigned m, q;
        neg = n < 0;
        m = neg ? -n : n;
        q = (m + longint'(d) / 2) / d;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void sin_cos(logic [31:0] ang, output longint c, output longint s);
        logic [1:0]  q;
        logic [31:0] rem;
        longint z, x, y, dx, dy;
        q = 2'((ang + 32'h2000_0000) >> 30);
        rem = ang - {q, 30'd0};
        z = longint'(rem);
        x = GAIN;
        y = 0;
        if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
        for (int i = 0; i < 31; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= atan_tab[i];
            end else begin
                x += dy; y -= dx; z += atan_tab[i];
            end
        end
        case (q)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic t_pose advance_pose(t_move mv);
        longint d1, d2, len, cv, sv, b, diff, s, dth, h, hq, mag, sinc, h2, h4, sh, ch, num;
        logic [31:0] dir, nh;
        t_pose r;
        d1 = clip32(round_div(longint'(mv.c1) * longint'(dist_per_count), 256));
        d2 = clip32(round_div(longint'(mv.c2) * longint'(dist_per_count), 256));
        if (mv.ms == 0 || d1 == d2) begin
            len = d1;
            dir = phd;
            nh = phd;
        end else begin
            b = (base_len == 0) ? 1 : longint'(base_len);
            diff = d1 - d2;
            s = round_div(d1 + d2, 2);
            dth = round_div(diff * RAD_BAM, b);
            h = dth >>> 1;
            hq = round_div(diff * (64'sd1 << 29), b);
            mag = hq < 0 ? -hq : hq;
            if (mag < (64'sd1 << 26)) begin
                h2 = round_div(mag * mag, ONE);
                h4 = round_div(h2 * h2, ONE);
                sinc = ONE - round_div(h2, 6) + round_div(h4, 120);
            end else begin
                sin_cos(32'(h), ch, sh);
                num = sh * ONE;
                if (hq < 0) num = -num;
                sinc = round_div(num, mag);
            end
            len = round_div(s * sinc, ONE);
            dir = phd - 32'(h);
            nh = phd - 32'(dth);
        end
        sin_cos(dir + QUARTER_TURN, cv, sv);
        px = 32'(clip32(longint'(px) + round_div(len * cv, ONE)));
        py = 32'(clip32(longint'(py) + round_div(len * sv, ONE)));
        phd = nh;
        r.x = px; r.y = py; r.hd = phd;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            expected_poses.push_back(advance_pose(cur_move));
            tx_gap = $urandom_range(0, 3);
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_moves.size() > 0) begin
                cur_move = pending_moves.pop_front();
                s_axis_tdata <= {cur_move.ms, cur_move.c2, cur_move.c1};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                poses_seen++;
                if (expected_poses.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
                    n_fail++;
                end else begin
                    e = expected_poses.pop_front();
                    if (m_axis_tdata[31:0] !== e.x) begin
                        $display("%0t: pos_x expected %h actual %h", $time, e.x,
                                 m_axis_tdata[31:0]);
                        n_fail++;
                    end
                    if (m_axis_tdata[63:32] !== e.y) begin
                        $display("%0t: pos_y expected %h actual %h", $time, e.y,
                                 m_axis_tdata[63:32]);
                        n_fail++;
                    end
                    if (m_axis_tdata[95:64] !== e.hd) begin
                        $display("%0t: heading expected %h actual %h", $time, e.hd,
                                 m_axis_tdata[95:64]);
                        n_fail++;
                    end
                end
                rx_wait = $urandom_range(0, 3);
                if (poses_seen == 700 && !hold_done) begin
                    hold_cycles = 3000;
                    hold_done = 1;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DPC) dist_per_count = val;
        else base_len = val[23:0];
    endtask

    // sampled away from the rising edge so driver updates are settled
    task automatic wait_idle();
        while (pending_moves.size() > 0 || expected_poses.size() > 0 || s_axis_tvalid)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic add_move(int c1, int c2, int ms);
        t_move m;
        m.c1 = 16'(c1); m.c2 = 16'(c2); m.ms = 16'(ms);
        pending_moves.push_back(m);
    endtask

    task automatic random_moves(int n);
        int a, k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 6) begin
                a = $urandom_range(0, 400) - 200;
                add_move(a, a + $urandom_range(0, 40) - 20, $urandom_range(1, 65535));
            end else if (k == 6) begin
                a = $urandom_range(0, 65535);
                add_move(a, a, $urandom_range(0, 65535));
            end else if (k == 7) begin
                add_move($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
            end else begin
                add_move($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            end
        end
    endtask

    initial begin
        logic [31:0] dpc_set[6];
        logic [23:0] wb_set[6];
        dpc_set = '{32'd125829, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'd2000000, 32'd125829};
        wb_set  = '{24'd1245184, 24'd1, 24'hFF_FFFF, 24'd1,
                    24'd65536, 24'd4000000};
        dist_per_count = DPC_RST;
        base_len = WB_RST;
        px = 0; py = 0; phd = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, straight, equal wheels, small and large arcs
        add_move(0, 0, 0);
        add_move(32767, 32767, 10);
        add_move(-32768, -32768, 10);
        add_move(32767, -32768, 0);
        add_move(100, 99, 20);
        add_move(100, 101, 65535);
        add_move(3200, -3200, 7);
        add_move(-3200, 3200, 7);
        add_move(32767, -32768, 1);
        add_move(-32768, 32767, 65535);
        add_move(500, 0, 3);
        add_move(0, 500, 3);
        add_move(-1, 1, 1);
        add_move(20000, 19000, 40);
        wait_idle();
        write_reg(CFG_DPC, 32'hFFFF_FFFF);
        write_reg(CFG_WB, 24'd1);
        // drive the position into saturation
        for (int i = 0; i < 6; i++) add_move(32767, 32767, 0);
        add_move(32767, -32768, 5);
        add_move(-32768, -32768, 0);
        wait_idle();
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_DPC, dpc_set[p]);
            write_reg(CFG_WB, {8'd0, wb_set[p]});
            random_moves(255);
            wait_idle();
        end
        repeat (50) @(posedge i_clk);
        if (n_fail == 0 && expected_poses.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/dado_pkg.sv
rtl/dado_mul.sv
rtl/dado_div.sv
rtl/dado_cordic.sv
rtl/differential_drive_arc_odometry.sv
rtl/dado_chk.sv
bench/tb_top.sv
